>>> hw/rtl/cdpr_pkg.sv
// ----------------------------------------------------------------------------
// cdpr_pkg
// types and constants shared by the complex dot-product reduction block
// ----------------------------------------------------------------------------
package cdpr_pkg;

	localparam int ELEM_BITS    = 16;
	localparam int PROD_BITS    = 2 * ELEM_BITS;
	localparam int SUM_BITS     = 48;
	localparam int IDX_BITS     = 8;
	localparam int CFG_BITS     = 9;
	localparam int CFG_IDX_BITS = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REDUCE_DIM = 2'd2;

	// reduction modes
	localparam logic [1:0] DIM_COLS = 2'd1;
	localparam logic [1:0] DIM_ROWS = 2'd2;

	typedef struct packed {
		logic signed [ELEM_BITS-1:0] a_re;
		logic signed [ELEM_BITS-1:0] a_im;
		logic signed [ELEM_BITS-1:0] b_re;
		logic signed [ELEM_BITS-1:0] b_im;
	} in_req_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum_re;
		logic signed [SUM_BITS-1:0] sum_im;
		logic [IDX_BITS-1:0]        out_index;
		logic                       final_result;
	} out_req_t;

	// per-element position and mode flags carried down the pipeline
	typedef struct packed {
		logic [IDX_BITS-1:0] row_idx;
		logic [IDX_BITS-1:0] col_idx;
		logic                last_row;
		logic                last_col;
		logic                first_col;
		logic                row_mode;
		logic                vec_scalar;
	} ctl_t;

endpackage

>>> hw/rtl/complex_dot_product_reduce_top.sv
// ----------------------------------------------------------------------------
// complex_dot_product_reduce_top
// streaming sum of conj(a)*b over column-major matrix element pairs
// ----------------------------------------------------------------------------
// usage
//   in channel: one request per element pair (a, b), column-major order,
//   accepted when in_valid and in_ready are both high
//   out channel: one request per finished sum, with its column or row index
//   and a flag on the last sum of the whole operation
//   config port: cfg_we writes cfg_data into register cfg_idx at once;
//   any write to a defined register restarts the operation; writes are to be
//   made only while the block is idle, which the block itself does not enforce
// throughput
//   one request per cycle sustained while the output does not stall, set by
//   the three-stage pipeline around the single read and single write port of
//   the row-sum memory
// reset
//   clears positions, running sum, pipeline valids and registers
//   (row_count = 1, col_count = 1, reduce_dim = 0); the row-sum memory is
//   not cleared, since column 0 always writes an entry before it is read
// stalls
//   the output register holds its result while out_ready is low; earlier
//   stages keep taking requests until they fill, then in_ready drops
// ----------------------------------------------------------------------------
module complex_dot_product_reduce_top #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cdpr_pkg::in_req_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cdpr_pkg::out_req_t                  out_data,
	input  logic                                cfg_we,
	input  logic [cdpr_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [cdpr_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int RCW  = $clog2(MAX_ROWS + 1);          // row count width
	localparam int RCW1 = RCW + 1;
	localparam int CCW  = $clog2(MAX_COLS + 1);          // column count width
	localparam int CCW1 = CCW + 1;
	localparam int RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;  // memory address
	localparam int SW   = cdpr_pkg::SUM_BITS;
	localparam int PW   = cdpr_pkg::PROD_BITS;

	// configuration registers
	logic [cdpr_pkg::CFG_BITS-1:0] row_count_q;
	logic [cdpr_pkg::CFG_BITS-1:0] col_count_q;
	logic [1:0]                    reduce_dim_q;
	logic                          cfg_hit;

	// position of the next element
	logic [RCW-1:0] row_q;
	logic [CCW-1:0] col_q;

	// running sum for the column and vector modes
	logic signed [SW-1:0] run_re_q;
	logic signed [SW-1:0] run_im_q;

	// effective sizes and flags of the element entering now
	logic [RCW-1:0] h_eff;
	logic [CCW-1:0] w_eff;
	logic           last_row_in;
	logic           last_col_in;
	cdpr_pkg::ctl_t ctl_in;

	// stage 1: captured request
	logic              v_s1;
	cdpr_pkg::in_req_t req_s1;
	cdpr_pkg::ctl_t    ctl_s1;
	logic [RAW-1:0]    addr_s1;

	// stage 2: products, memory read data arrives here
	logic                 v_s2;
	logic signed [PW-1:0] p_rr_s2;
	logic signed [PW-1:0] p_ii_s2;
	logic signed [PW-1:0] p_ri_s2;
	logic signed [PW-1:0] p_ir_s2;
	cdpr_pkg::ctl_t       ctl_s2;
	logic [RAW-1:0]       addr_s2;
	logic                 fwd_s2;
	logic [2*SW-1:0]      fwd_data_s2;

	// stage 3: output register
	logic               v_s3;
	cdpr_pkg::out_req_t out_s3;

	// handshake between stages
	logic adv3;
	logic adv2;
	logic fire1;
	logic fire2;
	logic accept;

	// stage 2 arithmetic
	logic signed [PW:0]   pre;
	logic signed [PW:0]   pim;
	logic [2*SW-1:0]      ram_rdata;
	logic [2*SW-1:0]      old_row;
	logic signed [SW-1:0] base_re;
	logic signed [SW-1:0] base_im;
	logic signed [SW-1:0] sum_re;
	logic signed [SW-1:0] sum_im;
	logic                 emit2;
	cdpr_pkg::out_req_t   out_next;
	logic                 ram_we;

	// ---------------------------------------------------------------- sizes
	// a count of zero acts as one, a count above the maximum as the maximum
	always_comb begin
		if (row_count_q == '0) begin
			h_eff = RCW'(1);
		end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
			h_eff = RCW'(MAX_ROWS);
		end else begin
			h_eff = RCW'(row_count_q);
		end
		if (col_count_q == '0) begin
			w_eff = CCW'(1);
		end else if (32'(col_count_q) > 32'(MAX_COLS)) begin
			w_eff = CCW'(MAX_COLS);
		end else begin
			w_eff = CCW'(col_count_q);
		end
	end

	assign last_row_in = (RCW1'(row_q) + RCW1'(1)) >= RCW1'(h_eff);
	assign last_col_in = (CCW1'(col_q) + CCW1'(1)) >= CCW1'(w_eff);

	// mode decisions are taken when the element enters
	always_comb begin
		ctl_in.row_idx    = cdpr_pkg::IDX_BITS'(row_q);
		ctl_in.col_idx    = cdpr_pkg::IDX_BITS'(col_q);
		ctl_in.last_row   = last_row_in;
		ctl_in.last_col   = last_col_in;
		ctl_in.first_col  = (col_q == '0);
		ctl_in.row_mode   = (reduce_dim_q == cdpr_pkg::DIM_ROWS);
		// vector shape in default mode folds to one scalar
		ctl_in.vec_scalar = (reduce_dim_q != cdpr_pkg::DIM_COLS) &&
			(reduce_dim_q != cdpr_pkg::DIM_ROWS) &&
			((h_eff == RCW'(1)) || (w_eff == CCW'(1)));
	end

	// ------------------------------------------------------------ handshake
	// each stage moves on when the one after it has room
	assign adv3     = !v_s3 || out_ready;
	assign fire2    = v_s2 && adv3;
	assign adv2     = !v_s2 || adv3;
	assign fire1    = v_s1 && adv2;
	assign in_ready = !v_s1 || adv2;
	assign accept   = in_valid && in_ready;

	assign cfg_hit = cfg_we && ((cfg_idx == cdpr_pkg::REG_ROW_COUNT) ||
		(cfg_idx == cdpr_pkg::REG_COL_COUNT) || (cfg_idx == cdpr_pkg::REG_REDUCE_DIM));

	// ------------------------------------------------------- row-sum memory
	// read when an element moves into stage 2, write back in row mode when it leaves
	assign ram_we = fire2 && ctl_s2.row_mode;

	cdpr_ram #(
		.WIDTH(2 * SW),
		.DEPTH(MAX_ROWS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s2),
		.wdata({sum_re, sum_im}),
		.re   (fire1),
		.raddr(addr_s1),
		.rdata(ram_rdata)
	);

	// ----------------------------------------------------- stage 2 datapath
	assign pre = {p_rr_s2[PW-1], p_rr_s2} + {p_ii_s2[PW-1], p_ii_s2};
	assign pim = {p_ri_s2[PW-1], p_ri_s2} - {p_ir_s2[PW-1], p_ir_s2};

	// a write in the same cycle as the read is taken from the forward copy
	assign old_row = fwd_s2 ? fwd_data_s2 : ram_rdata;

	always_comb begin
		if (ctl_s2.row_mode) begin
			if (ctl_s2.first_col) begin
				base_re = '0;
				base_im = '0;
			end else begin
				base_re = old_row[2*SW-1:SW];
				base_im = old_row[SW-1:0];
			end
		end else begin
			base_re = run_re_q;
			base_im = run_im_q;
		end
	end

	assign sum_re = base_re + {{(SW-PW-1){pre[PW]}}, pre};
	assign sum_im = base_im + {{(SW-PW-1){pim[PW]}}, pim};

	always_comb begin
		out_next.sum_re = sum_re;
		out_next.sum_im = sum_im;
		if (ctl_s2.row_mode) begin
			// row sums leave during the last column
			emit2                 = ctl_s2.last_col;
			out_next.out_index    = ctl_s2.row_idx;
			out_next.final_result = ctl_s2.last_row;
		end else if (ctl_s2.vec_scalar) begin
			emit2                 = ctl_s2.last_row && ctl_s2.last_col;
			out_next.out_index    = '0;
			out_next.final_result = ctl_s2.last_col;
		end else begin
			emit2                 = ctl_s2.last_row;
			out_next.out_index    = ctl_s2.col_idx;
			out_next.final_result = ctl_s2.last_col;
		end
	end

	// --------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= cdpr_pkg::CFG_BITS'(1);
			col_count_q  <= cdpr_pkg::CFG_BITS'(1);
			reduce_dim_q <= '0;
			row_q        <= '0;
			col_q        <= '0;
			run_re_q     <= '0;
			run_im_q     <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					cdpr_pkg::REG_ROW_COUNT: begin
						row_count_q <= cfg_data;
					end
					cdpr_pkg::REG_COL_COUNT: begin
						col_count_q <= cfg_data;
					end
					cdpr_pkg::REG_REDUCE_DIM: begin
						reduce_dim_q <= cfg_data[1:0];
					end
					default: begin
					end
				endcase
			end

			// position counters step per accepted request
			if (cfg_hit) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (last_row_in) begin
					row_q <= '0;
					if (last_col_in) begin
						col_q <= '0;
					end else begin
						col_q <= col_q + CCW'(1);
					end
				end else begin
					row_q <= row_q + RCW'(1);
				end
			end

			// running sum clears on emit and at the end of an operation
			if (cfg_hit) begin
				run_re_q <= '0;
				run_im_q <= '0;
			end else if (fire2) begin
				if (ctl_s2.row_mode) begin
					if (ctl_s2.last_row && ctl_s2.last_col) begin
						run_re_q <= '0;
						run_im_q <= '0;
					end
				end else if (emit2) begin
					run_re_q <= '0;
					run_im_q <= '0;
				end else begin
					run_re_q <= sum_re;
					run_im_q <= sum_im;
				end
			end

			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2 && emit2;
			end
		end
	end

	// --------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= in_data;
			ctl_s1  <= ctl_in;
			addr_s1 <= row_q[RAW-1:0];
		end
		if (fire1) begin
			// operands widened with sign before the multiply
			p_rr_s2     <= PW'(req_s1.a_re) * PW'(req_s1.b_re);
			p_ii_s2     <= PW'(req_s1.a_im) * PW'(req_s1.b_im);
			p_ri_s2     <= PW'(req_s1.a_re) * PW'(req_s1.b_im);
			p_ir_s2     <= PW'(req_s1.a_im) * PW'(req_s1.b_re);
			ctl_s2      <= ctl_s1;
			addr_s2     <= addr_s1;
			// same row written back in this cycle
			fwd_s2      <= ram_we && (addr_s2 == addr_s1);
			fwd_data_s2 <= {sum_re, sum_im};
		end
		if (fire2 && emit2) begin
			out_s3 <= out_next;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = out_s3;

endmodule

>>> hw/rtl/cdpr_ram.sv
// ----------------------------------------------------------------------------
// cdpr_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module cdpr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/cdpr_checker.sv
// ----------------------------------------------------------------------------
// cdpr_port_checker
// port-level checks for the complex dot-product reduction block
// ----------------------------------------------------------------------------
module cdpr_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input cdpr_pkg::out_req_t out_data
);

	// no result is shown while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> (out_valid !== 1'b1))
		else $error("out_valid high during reset");

	// with the output free the pipeline always has room
	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("in_ready low while the output side can move");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed or dropped");

	// while a result stays stalled and in_ready is low, in_ready stays low
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !in_ready) |=> !in_ready || out_ready || !out_valid)
		else $error("in_ready rose while the full pipeline stayed stalled");

endmodule

bind complex_dot_product_reduce_top cdpr_port_checker u_cdpr_port_checker (.*);
